// ----- hw/rtl/tklt_pkg.sv -----
// Shared types, codes and key functions for the ranked list tracker.
package tklt_pkg;

    localparam int ID_W  = 16;
    localparam int LEN_W = 6;
    localparam int CNT_W = 20;
    localparam int SUM_W = 21;

    // Transaction kinds on the command channel.
    localparam logic [1:0] KIND_OFFER = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Ranking modes.
    localparam logic [1:0] MODE_LENGTH    = 2'd0;
    localparam logic [1:0] MODE_USED_DESC = 2'd1;
    localparam logic [1:0] MODE_USED_ASC  = 2'd2;

    // Count selection.
    localparam logic [1:0] BOOK_A    = 2'd0;
    localparam logic [1:0] BOOK_B    = 2'd1;
    localparam logic [1:0] BOOK_BOTH = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RANK_MODE   = 2'd0;
    localparam logic [1:0] REG_BOOK_SELECT = 2'd1;
    localparam logic [1:0] REG_LIST_SIZE   = 2'd2;

    localparam logic [4:0] LIST_SIZE_RESET = 5'd5;

    // One ranked entry as it is stored.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic offer_do;
        logic sort_en;
        logic sort_odd;
        logic rd_en;
        logic rd_last;
    } dp_cmd_t;

    // Selected count, or the sum of both counts.
    function automatic logic [SUM_W-1:0] count_of(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b,
                                                  input logic [1:0] sel);
        logic [SUM_W-1:0] res;
        case (sel)
            BOOK_A:    res = {1'b0, a};
            BOOK_B:    res = {1'b0, b};
            BOOK_BOTH: res = {1'b0, a} + {1'b0, b};
            default:   res = '0;
        endcase
        return res;
    endfunction

    // An offer counts only when the selected counts are nonzero.
    function automatic logic is_eligible(input logic [CNT_W-1:0] a,
                                         input logic [CNT_W-1:0] b,
                                         input logic [1:0] sel);
        logic res;
        case (sel)
            BOOK_A:    res = (a != '0);
            BOOK_B:    res = (b != '0);
            BOOK_BOTH: res = (a != '0) && (b != '0);
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

    // Ranking key of an entry under the current mode and selection.
    function automatic logic [SUM_W-1:0] key_of(input slot_t s,
                                                input logic [1:0] mode,
                                                input logic [1:0] sel);
        logic [SUM_W-1:0] res;
        if (mode == MODE_USED_DESC || mode == MODE_USED_ASC)
        begin
            res = count_of(s.a, s.b, sel);
        end
        else
        begin
            res = SUM_W'(s.len);
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/tklt_regs.sv -----
// Configuration register bank behind the APB-style port.
module tklt_regs #(
    parameter int MAX_K = 16,
    localparam int CW = $clog2(MAX_K + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output logic [1:0]    rank_mode,
    output logic [1:0]    book_select,
    output logic [CW-1:0] eff_size
);

    logic [1:0] rank_mode_reg;
    logic [1:0] book_select_reg;
    logic [4:0] list_size_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes at the access phase of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_mode_reg   <= tklt_pkg::MODE_LENGTH;
            book_select_reg <= tklt_pkg::BOOK_A;
            list_size_reg   <= tklt_pkg::LIST_SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                tklt_pkg::REG_RANK_MODE:   rank_mode_reg   <= pwdata[1:0];
                tklt_pkg::REG_BOOK_SELECT: book_select_reg <= pwdata[1:0];
                tklt_pkg::REG_LIST_SIZE:   list_size_reg   <= pwdata[4:0];
                default:                   ;
            endcase
        end
    end

    // Read-back of the register values.
    always_comb
    begin
        case (paddr[3:2])
            tklt_pkg::REG_RANK_MODE:   prdata = {30'd0, rank_mode_reg};
            tklt_pkg::REG_BOOK_SELECT: prdata = {30'd0, book_select_reg};
            tklt_pkg::REG_LIST_SIZE:   prdata = {27'd0, list_size_reg};
            default:                   prdata = '0;
        endcase
    end

    // Size zero acts as one, and sizes above the slot count are clamped.
    always_comb
    begin
        if (list_size_reg == 5'd0)
        begin
            eff_size = CW'(1);
        end
        else if (int'(list_size_reg) > MAX_K)
        begin
            eff_size = CW'(MAX_K);
        end
        else
        begin
            eff_size = CW'(list_size_reg);
        end
    end

    assign rank_mode   = rank_mode_reg;
    assign book_select = book_select_reg;

endmodule

// ----- hw/rtl/tklt_ctrl.sv -----
// Controller state machine: sequences offers, sort phases and read-outs.
module tklt_ctrl #(
    parameter int MAX_K = 16,
    localparam int CW = $clog2(MAX_K + 1),
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [CW-1:0]     eff_size,
    input  logic              sort_needed,
    output logic              busy,
    output tklt_pkg::dp_cmd_t cmd,
    output logic [IW-1:0]     rd_addr
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OFFER = 4'b0010,
        ST_SORT  = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          cnt_at_end;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign cnt_at_end = (cnt_reg == eff_size - CW'(1));

    // Next state, counter and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        rd_addr    = cnt_reg[IW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                cnt_next = '0;
                if (accept)
                begin
                    case (kind)
                        tklt_pkg::KIND_OFFER: state_next = ST_OFFER;
                        tklt_pkg::KIND_READ:  state_next = ST_READ;
                        tklt_pkg::KIND_CLEAR: cmd.clear  = 1'b1;
                        default:              ;
                    endcase
                end
            end
            ST_OFFER:
            begin
                cmd.offer_do = 1'b1;
                rd_addr      = IW'(eff_size - CW'(1));
                state_next   = sort_needed ? ST_SORT : ST_IDLE;
            end
            ST_SORT:
            begin
                cmd.sort_en  = 1'b1;
                cmd.sort_odd = cnt_reg[0];
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = cnt_at_end;
                cnt_next    = cnt_reg + CW'(1);
                if (cnt_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/tklt_dp.sv -----
// Datapath: slot registers, tail compare, odd-even sort cells and read-out port.
module tklt_dp #(
    parameter int MAX_K = 16,
    localparam int CW = $clog2(MAX_K + 1),
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tklt_pkg::dp_cmd_t cmd,
    input  logic [IW-1:0]     rd_addr,
    input  logic [1:0]        rank_mode,
    input  logic [1:0]        book_select,
    input  logic [CW-1:0]     eff_size,
    input  logic [15:0]       word_id,
    input  logic [5:0]        word_length,
    input  logic [19:0]       count_a,
    input  logic [19:0]       count_b,
    output logic              sort_needed,
    output logic              result_strobe,
    output logic [15:0]       slot_word_id,
    output logic [5:0]        slot_length,
    output logic [20:0]       slot_count,
    output logic              slot_valid,
    output logic              last
);

    tklt_pkg::slot_t           slots_reg [MAX_K];
    tklt_pkg::slot_t           slots_next [MAX_K];
    tklt_pkg::slot_t           in_reg;
    tklt_pkg::slot_t           rd_slot;
    logic [tklt_pkg::SUM_W-1:0] keys [MAX_K];
    logic [tklt_pkg::SUM_W-1:0] in_key;
    logic [tklt_pkg::SUM_W-1:0] tail_key;
    logic [tklt_pkg::SUM_W-1:0] least_key;
    logic [MAX_K-1:0]          swap;
    logic [CW-1:0]             fill_reg;
    logic                      eligible;
    logic                      appending;
    logic                      take;
    logic                      ascending;
    logic                      rd_valid;
    logic                      strobe_reg;
    logic [15:0]               id_reg;
    logic [5:0]                len_reg;
    logic [20:0]               count_reg;
    logic                      valid_reg;
    logic                      last_reg;

    // Latch the offered entry when a transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= '{id: word_id, len: word_length, a: count_a, b: count_b};
        end
    end

    // Single read port, shared by the tail compare and the read-out.
    assign rd_slot = slots_reg[rd_addr];

    // Offer decision against the tail slot.
    assign ascending = (rank_mode == tklt_pkg::MODE_USED_ASC);
    assign eligible  = tklt_pkg::is_eligible(in_reg.a, in_reg.b, book_select);
    assign appending = (fill_reg < eff_size);
    assign in_key    = tklt_pkg::key_of(in_reg, rank_mode, book_select);
    assign tail_key  = tklt_pkg::key_of(rd_slot, rank_mode, book_select);
    assign least_key = (book_select == tklt_pkg::BOOK_BOTH) ?
                       tklt_pkg::SUM_W'(2) : tklt_pkg::SUM_W'(1);

    always_comb
    begin
        if (ascending)
        begin
            take = (in_key < tail_key) || (in_key == least_key);
        end
        else
        begin
            take = (in_key > tail_key);
        end
    end

    // The list gets sorted once the offer leaves it full.
    assign sort_needed = eligible &&
                         (({1'b0, fill_reg} + (CW + 1)'(1)) >= {1'b0, eff_size});

    // Compare cells between neighbouring slots; one parity per sort phase.
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            keys[i] = tklt_pkg::key_of(slots_reg[i], rank_mode, book_select);
        end
        swap = '0;
        for (int w = 0; w < MAX_K - 1; w++)
        begin
            swap[w] = (((w & 1) == 1) == cmd.sort_odd) && ((w + 1) < int'(eff_size)) &&
                      (ascending ? (keys[w] > keys[w+1]) : (keys[w] < keys[w+1]));
        end
    end

    // Next contents of the slots: a sort phase or an offer write.
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            slots_next[i] = slots_reg[i];
        end
        if (cmd.sort_en)
        begin
            for (int w = 0; w < MAX_K - 1; w++)
            begin
                if (swap[w])
                begin
                    slots_next[w]   = slots_reg[w+1];
                    slots_next[w+1] = slots_reg[w];
                end
            end
        end
        else if (cmd.offer_do && eligible)
        begin
            if (appending)
            begin
                slots_next[fill_reg[IW-1:0]] = in_reg;
            end
            else if (take)
            begin
                slots_next[rd_addr] = in_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            slots_reg[i] <= slots_next[i];
        end
    end

    // Fill level of the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.clear)
        begin
            fill_reg <= '0;
        end
        else if (cmd.offer_do && eligible && appending)
        begin
            fill_reg <= fill_reg + CW'(1);
        end
    end

    // Read-out output register; empty slots read as zero.
    assign rd_valid = (CW'(rd_addr) < fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            id_reg    <= rd_valid ? rd_slot.id : '0;
            len_reg   <= rd_valid ? rd_slot.len : '0;
            count_reg <= rd_valid ?
                         tklt_pkg::count_of(rd_slot.a, rd_slot.b, book_select) : '0;
            valid_reg <= rd_valid;
            last_reg  <= cmd.rd_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign slot_word_id  = id_reg;
    assign slot_length   = len_reg;
    assign slot_count    = count_reg;
    assign slot_valid    = valid_reg;
    assign last          = last_reg;

endmodule

// ----- hw/rtl/top_k_ranked_list_tracker_core.sv -----
// Top level of the ranked list tracker: register bank, controller and datapath.
//
// Usage. A command transaction is taken at a clock edge where start is high and
// busy is low; kind selects an offer, a read-out or a clear. Configuration is
// written over the APB-style port (rank mode at 0x0, count select at 0x4, list
// size at 0x8) while the block is idle; pready is always high.
// Operation. A clear takes effect at once and busy stays low. An offer keeps
// busy high through its tail compare, and on through the sort when it is
// eligible and leaves the list full, n being the list size in use: the stable
// sort runs as n odd-even phases of one compare cell per slot pair.
// A read-out keeps busy high while it reads the n slots and returns n results,
// one per cycle on result_strobe, the first once the controller is in its read
// state and the output register has taken the slot; last marks the final slot.
// The offer rate is set by the sort phases, the read-out rate by the single slot read port.
// Reset clears the fill level and loads the register defaults (list size 5);
// the slot contents need no reset. Results are shown for one cycle only; the
// receiver cannot stall them.
module top_k_ranked_list_tracker_core #(
    parameter int MAX_K = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [15:0] word_id,
    input  logic [5:0]  word_length,
    input  logic [19:0] count_a,
    input  logic [19:0] count_b,
    output logic        result_strobe,
    output logic [15:0] slot_word_id,
    output logic [5:0]  slot_length,
    output logic [20:0] slot_count,
    output logic        slot_valid,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_K + 1);
    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    tklt_pkg::dp_cmd_t cmd;
    logic [IW-1:0]     rd_addr;
    logic [1:0]        rank_mode;
    logic [1:0]        book_select;
    logic [CW-1:0]     eff_size;
    logic              sort_needed;

    tklt_regs #(.MAX_K(MAX_K)) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rank_mode   (rank_mode),
        .book_select (book_select),
        .eff_size    (eff_size)
    );

    tklt_ctrl #(.MAX_K(MAX_K)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .eff_size    (eff_size),
        .sort_needed (sort_needed),
        .busy        (busy),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    tklt_dp #(.MAX_K(MAX_K)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .rank_mode     (rank_mode),
        .book_select   (book_select),
        .eff_size      (eff_size),
        .word_id       (word_id),
        .word_length   (word_length),
        .count_a       (count_a),
        .count_b       (count_b),
        .sort_needed   (sort_needed),
        .result_strobe (result_strobe),
        .slot_word_id  (slot_word_id),
        .slot_length   (slot_length),
        .slot_count    (slot_count),
        .slot_valid    (slot_valid),
        .last          (last)
    );

    // A result only ever follows a read-out cycle of the controller.
    a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(cmd.rd_en))
        else $error("result transaction without a read-out cycle");

    // An accepted read-out delivers its first slot through the read state and the output register.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == tklt_pkg::KIND_READ) |-> ##2 result_strobe)
        else $error("read-out did not deliver its first slot in time");

    // The sort and the read port are never driven in the same cycle.
    a_sort_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sort_en && (cmd.rd_en || cmd.offer_do)))
        else $error("sort phase overlaps another datapath command");

endmodule

// ----- tb/sv/top_k_ranked_list_tracker_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ranked list tracker core, predicting read-outs and comparing each slot.
module top_k_ranked_list_tracker_core_test;

    localparam int K = 16;

    // Codes that the package leaves unnamed because the block treats them as spare.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] BOOK_NONE  = 2'd3;

    typedef struct {
        logic [1:0]                 kind;
        logic [tklt_pkg::ID_W-1:0]  id;
        logic [tklt_pkg::LEN_W-1:0] len;
        logic [tklt_pkg::CNT_W-1:0] a;
        logic [tklt_pkg::CNT_W-1:0] b;
    } cmd_t;

    typedef struct {
        logic [tklt_pkg::ID_W-1:0]  id;
        logic [tklt_pkg::LEN_W-1:0] len;
        logic [tklt_pkg::SUM_W-1:0] count;
        logic                       valid;
        logic                       last;
    } slot_read_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 kind = tklt_pkg::KIND_OFFER;
    logic [tklt_pkg::ID_W-1:0]  word_id = '0;
    logic [tklt_pkg::LEN_W-1:0] word_length = '0;
    logic [tklt_pkg::CNT_W-1:0] count_a = '0;
    logic [tklt_pkg::CNT_W-1:0] count_b = '0;
    logic                       result_strobe;
    logic [tklt_pkg::ID_W-1:0]  slot_word_id;
    logic [tklt_pkg::LEN_W-1:0] slot_length;
    logic [tklt_pkg::SUM_W-1:0] slot_count;
    logic                       slot_valid;
    logic                       last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [3:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Commands waiting for the driver, and slots that read-outs still owe us.
    cmd_t        cmds_pending[$];
    slot_read_t  slots_due[$];
    cmd_t        next_cmd;
    slot_read_t  due;
    logic        cmd_taken = 1'b0;
    int          cmds_issued = 0;
    int          cmds_taken = 0;
    int          idle_pct = 0;
    int          errors = 0;

    // Predicted contents of the block: configuration, ranked slots and fill level.
    logic [1:0]       cfg_mode = tklt_pkg::MODE_LENGTH;
    logic [1:0]       cfg_book = tklt_pkg::BOOK_A;
    logic [4:0]       cfg_size = tklt_pkg::LIST_SIZE_RESET;
    tklt_pkg::slot_t  ranks [K];
    int               rank_fill = 0;

    top_k_ranked_list_tracker_core #(
        .MAX_K(K)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .word_id(word_id),
        .word_length(word_length),
        .count_a(count_a),
        .count_b(count_b),
        .result_strobe(result_strobe),
        .slot_word_id(slot_word_id),
        .slot_length(slot_length),
        .slot_count(slot_count),
        .slot_valid(slot_valid),
        .last(last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of slots that take part in ranking; out-of-range sizes are clamped.
    function automatic int ranks_in_use();
        int n;
        if (cfg_size == 5'd0)
            n = 1;
        else if (int'(cfg_size) > K)
            n = K;
        else
            n = int'(cfg_size);
        return n;
    endfunction

    // Count shown for an entry under the current book selection.
    function automatic logic [tklt_pkg::SUM_W-1:0] book_count(
        input logic [tklt_pkg::CNT_W-1:0] a,
        input logic [tklt_pkg::CNT_W-1:0] b);
        logic [tklt_pkg::SUM_W-1:0] c;
        case (cfg_book)
            tklt_pkg::BOOK_A:    c = {1'b0, a};
            tklt_pkg::BOOK_B:    c = {1'b0, b};
            tklt_pkg::BOOK_BOTH: c = {1'b0, a} + {1'b0, b};
            default:             c = '0;
        endcase
        return c;
    endfunction

    function automatic logic offer_counts(input logic [tklt_pkg::CNT_W-1:0] a,
                                          input logic [tklt_pkg::CNT_W-1:0] b);
        logic ok;
        case (cfg_book)
            tklt_pkg::BOOK_A:    ok = (a != '0);
            tklt_pkg::BOOK_B:    ok = (b != '0);
            tklt_pkg::BOOK_BOTH: ok = (a != '0) && (b != '0);
            default:             ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [tklt_pkg::SUM_W-1:0] rank_key(input tklt_pkg::slot_t s);
        logic [tklt_pkg::SUM_W-1:0] k;
        if (cfg_mode == tklt_pkg::MODE_USED_DESC || cfg_mode == tklt_pkg::MODE_USED_ASC)
            k = book_count(s.a, s.b);
        else
            k = tklt_pkg::SUM_W'(s.len);
        return k;
    endfunction

    // Stable bubble sort of the first n slots; only the usage-ascending mode sorts upwards.
    function automatic void sort_ranks(input int n);
        tklt_pkg::slot_t            t;
        logic [tklt_pkg::SUM_W-1:0] k0;
        logic [tklt_pkg::SUM_W-1:0] k1;
        logic                       up;
        up = (cfg_mode == tklt_pkg::MODE_USED_ASC);
        for (int p = 0; p + 1 < n; p++)
        begin
            for (int w = 0; w + 1 < n - p; w++)
            begin
                k0 = rank_key(ranks[w]);
                k1 = rank_key(ranks[w + 1]);
                if (up ? (k0 > k1) : (k0 < k1))
                begin
                    t = ranks[w];
                    ranks[w] = ranks[w + 1];
                    ranks[w + 1] = t;
                end
            end
        end
    endfunction

    // An eligible offer is appended while there is room, else it may displace the tail.
    function automatic void offer_entry(input tklt_pkg::slot_t e);
        int                         n;
        logic [tklt_pkg::SUM_W-1:0] k;
        logic [tklt_pkg::SUM_W-1:0] tail_key;
        logic [tklt_pkg::SUM_W-1:0] least;
        logic                       take;
        n = ranks_in_use();
        if (!offer_counts(e.a, e.b))
            return;
        if (rank_fill < n)
        begin
            ranks[rank_fill] = e;
            rank_fill++;
        end
        else
        begin
            k = rank_key(e);
            tail_key = rank_key(ranks[n - 1]);
            if (cfg_mode == tklt_pkg::MODE_USED_ASC)
            begin
                // The smallest possible key always wins the tail, even on a tie.
                least = (cfg_book == tklt_pkg::BOOK_BOTH) ?
                        tklt_pkg::SUM_W'(2) : tklt_pkg::SUM_W'(1);
                take = (k < tail_key) || (k == least);
            end
            else
            begin
                take = (k > tail_key);
            end
            if (take)
                ranks[n - 1] = e;
        end
        if (rank_fill >= n)
            sort_ranks(n);
    endfunction

    // A read-out owes one result per slot in use; slots never filled read as zero.
    function automatic void read_out_ranks();
        int          n;
        slot_read_t  r;
        n = ranks_in_use();
        for (int i = 0; i < n; i++)
        begin
            r.valid = (i < rank_fill);
            r.id    = r.valid ? ranks[i].id : '0;
            r.len   = r.valid ? ranks[i].len : '0;
            r.count = r.valid ? book_count(ranks[i].a, ranks[i].b) : '0;
            r.last  = (i == n - 1);
            slots_due.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Driver: a transaction is held until it is taken, then the next is offered or start drops.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !cmd_taken))
        begin
            if (cmds_pending.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                next_cmd = cmds_pending.pop_front();
                start       <= 1'b1;
                kind        <= next_cmd.kind;
                word_id     <= next_cmd.id;
                word_length <= next_cmd.len;
                count_a     <= next_cmd.a;
                count_b     <= next_cmd.b;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted transaction, and check each strobed slot in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken = start && !busy;
            if (cmd_taken)
            begin
                cmds_taken++;
                case (kind)
                    tklt_pkg::KIND_OFFER: offer_entry(tklt_pkg::slot_t'{id: word_id,
                                                      len: word_length,
                                                      a: count_a, b: count_b});
                    tklt_pkg::KIND_READ:  read_out_ranks();
                    tklt_pkg::KIND_CLEAR: rank_fill = 0;
                    default:              ;
                endcase
            end
            if (result_strobe === 1'b1)
            begin
                if (slots_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected slot, id %h", slot_word_id));
                end
                else
                begin
                    due = slots_due.pop_front();
                    if (slot_word_id !== due.id)
                        report_mismatch($sformatf("slot_word_id %h, expected %h",
                                                  slot_word_id, due.id));
                    if (slot_length !== due.len)
                        report_mismatch($sformatf("slot_length %0d, expected %0d",
                                                  slot_length, due.len));
                    if (slot_count !== due.count)
                        report_mismatch($sformatf("slot_count %0d, expected %0d",
                                                  slot_count, due.count));
                    if (slot_valid !== due.valid)
                        report_mismatch($sformatf("slot_valid %b, expected %b",
                                                  slot_valid, due.valid));
                    if (last !== due.last)
                        report_mismatch($sformatf("last %b, expected %b", last, due.last));
                end
            end
        end
    end

    // Register write: setup cycle, then access cycle; the write lands at the edge ending it.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            tklt_pkg::REG_RANK_MODE:   cfg_mode = value[1:0];
            tklt_pkg::REG_BOOK_SELECT: cfg_book = value[1:0];
            tklt_pkg::REG_LIST_SIZE:   cfg_size = value[4:0];
            default:                   ;
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic [1:0] book,
                             input logic [4:0] size);
        write_reg(tklt_pkg::REG_RANK_MODE, 32'(mode));
        write_reg(tklt_pkg::REG_BOOK_SELECT, 32'(book));
        write_reg(tklt_pkg::REG_LIST_SIZE, 32'(size));
        @(posedge clk);
    endtask

    task automatic queue_cmd(input logic [1:0] k, input logic [tklt_pkg::ID_W-1:0] id,
                             input logic [tklt_pkg::LEN_W-1:0] len,
                             input logic [tklt_pkg::CNT_W-1:0] a,
                             input logic [tklt_pkg::CNT_W-1:0] b);
        cmds_pending.push_back(cmd_t'{kind: k, id: id, len: len, a: a, b: b});
        cmds_issued++;
    endtask

    // Wait until every transaction is taken, every slot has arrived and the sort has finished.
    task automatic settle();
        do
            @(negedge clk);
        while (cmds_taken != cmds_issued || slots_due.size() != 0 || busy !== 1'b0);
        repeat (2 * K + 4) @(negedge clk);
    endtask

    // Counts lean towards zero, one, two and small values so that ties and minimum keys occur.
    function automatic logic [tklt_pkg::CNT_W-1:0] random_count();
        logic [tklt_pkg::CNT_W-1:0] c;
        case ($urandom_range(9))
            0:       c = '0;
            1:       c = tklt_pkg::CNT_W'(1);
            2:       c = tklt_pkg::CNT_W'(2);
            3, 4:    c = tklt_pkg::CNT_W'($urandom_range(15));
            5:       c = '1;
            default: c = tklt_pkg::CNT_W'($urandom);
        endcase
        return c;
    endfunction

    // Mostly offers so that the list fills and ranking is exercised, with read-outs between.
    task automatic random_phase(input logic [1:0] mode, input logic [1:0] book,
                                input logic [4:0] size, input int idle);
        int                         done;
        int                         pick;
        logic [tklt_pkg::LEN_W-1:0] len;
        configure(mode, book, size);
        idle_pct = idle;
        done = 0;
        while (done < 20)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(1) == 1) ? tklt_pkg::LEN_W'($urandom_range(7)) :
                                             tklt_pkg::LEN_W'($urandom);
            if (pick < 80)
            begin
                queue_cmd(tklt_pkg::KIND_OFFER, tklt_pkg::ID_W'($urandom), len,
                          random_count(), random_count());
                done++;
            end
            else if (pick < 94)
            begin
                queue_cmd(tklt_pkg::KIND_READ, tklt_pkg::ID_W'($urandom), len,
                          random_count(), random_count());
                done++;
            end
            else if (pick < 97)
            begin
                queue_cmd(tklt_pkg::KIND_CLEAR, tklt_pkg::ID_W'($urandom), len,
                          random_count(), random_count());
                done++;
            end
            else
            begin
                queue_cmd(KIND_SPARE, tklt_pkg::ID_W'($urandom), len,
                          random_count(), random_count());
            end
        end
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: length ranking, first book, five slots.
        idle_pct = 25;
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'h0000, 6'd0, 20'd1, 20'd0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'hFFFF, 6'd63, 20'hFFFFF, 20'hFFFFF);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'h1234, 6'd40, 20'd0, 20'd9);
        queue_cmd(KIND_SPARE, 16'hFFFF, 6'd63, 20'hFFFFF, 20'hFFFFF);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd2, 6'd10, 20'd5, 20'd0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd3, 6'd10, 20'd7, 20'd0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd4, 6'd20, 20'd1, 20'd0);
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd5, 6'd0, 20'd9, 20'd0);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd6, 6'd1, 20'd1, 20'd0);
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        queue_cmd(tklt_pkg::KIND_CLEAR, '0, '0, '0, '0);
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        settle();

        // Directed part in ascending mode on both books: largest sum and the minimum-key tie.
        configure(tklt_pkg::MODE_USED_ASC, tklt_pkg::BOOK_BOTH, 5'd2);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd7, 6'd3, 20'd3, 20'd4);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd8, 6'd63, 20'hFFFFF, 20'hFFFFF);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd9, 6'd5, 20'd1, 20'd1);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd10, 6'd6, 20'd1, 20'd1);
        queue_cmd(tklt_pkg::KIND_OFFER, 16'd11, 6'd7, 20'd5, 20'd0);
        queue_cmd(tklt_pkg::KIND_READ, '0, '0, '0, '0);
        settle();

        // Random phases over many settings, sender idling at 25 %, then 50 %, then never.
        random_phase(tklt_pkg::MODE_USED_DESC, tklt_pkg::BOOK_B, 5'd16, 25);
        random_phase(tklt_pkg::MODE_USED_ASC, tklt_pkg::BOOK_BOTH, 5'd1, 25);
        random_phase(MODE_SPARE, tklt_pkg::BOOK_A, 5'd0, 25);
        random_phase(tklt_pkg::MODE_USED_ASC, tklt_pkg::BOOK_A, 5'd31, 50);
        random_phase(tklt_pkg::MODE_LENGTH, tklt_pkg::BOOK_BOTH, 5'd8, 50);
        random_phase(tklt_pkg::MODE_USED_DESC, BOOK_NONE, 5'd3, 50);
        random_phase(tklt_pkg::MODE_USED_ASC, tklt_pkg::BOOK_B, 5'd4, 0);
        random_phase(tklt_pkg::MODE_USED_DESC, tklt_pkg::BOOK_BOTH, 5'd12, 0);
        random_phase(tklt_pkg::MODE_LENGTH, tklt_pkg::BOOK_A, 5'd16, 0);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/tklt_pkg.sv
hw/rtl/tklt_regs.sv
hw/rtl/tklt_ctrl.sv
hw/rtl/tklt_dp.sv
hw/rtl/top_k_ranked_list_tracker_core.sv
tb/sv/top_k_ranked_list_tracker_core_test.sv
